/* hw/rtl/dilp_pkg.sv */
// shared constants and types of the decimal line parser
`default_nettype none

package dilp_pkg;

    // line buffer size; the digit stack holds one less
    localparam int BUFFER_BYTES = 16;
    localparam int STACK_DEPTH  = BUFFER_BYTES - 1;
    localparam int IDX_W        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W        = $clog2(STACK_DEPTH + 1);

    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 4;
    localparam int NUM_W   = 32;

    // character codes
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_ACC  = 3'b010,
        ST_SIGN = 3'b100
    } t_state;

    // shared arithmetic unit operations
    typedef enum logic {
        ALU_MAC = 1'b0,
        ALU_NEG = 1'b1
    } t_alu_op;

    typedef struct packed {
        t_alu_op            op;
        logic [NUM_W-1:0]   acc;
        logic [DIGIT_W-1:0] digit;
    } t_alu_req;

    // digit stack ports
    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   addr;
        logic [DIGIT_W-1:0] data;
    } t_stk_wr;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } t_stk_rd;

endpackage

`default_nettype wire

/* hw/rtl/dilp_char_if.sv */
// character input channel interface
`default_nettype none

interface dilp_char_if import dilp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

`default_nettype wire

/* hw/rtl/dilp_num_if.sv */
// parsed number output channel interface
`default_nettype none

interface dilp_num_if import dilp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [NUM_W-1:0] number_value;

    modport source (output valid, output number_value, input ready);
    modport sink   (input valid, input number_value, output ready);
endinterface

`default_nettype wire

/* hw/rtl/dilp_stack.sv */
// digit stack memory with one write port and a registered read port
`default_nettype none

module dilp_stack import dilp_pkg::*; (
    input  wire logic               i_clk,
    input  wire t_stk_wr            i_wr,
    input  wire t_stk_rd            i_rd,
    output logic [DIGIT_W-1:0]      o_rd_data
);

    logic [DIGIT_W-1:0] r_mem [STACK_DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            o_rd_data <= r_mem[i_rd.addr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/dilp_alu.sv */
// shared arithmetic unit: multiply by ten and add a digit, or negate
`default_nettype none

module dilp_alu import dilp_pkg::*; (
    input  wire t_alu_req          i_req,
    output logic [NUM_W-1:0]       o_res
);

    always_comb begin
        case (i_req.op)
            ALU_MAC: o_res = (i_req.acc << 3) + (i_req.acc << 1) + NUM_W'(i_req.digit);
            ALU_NEG: o_res = (~i_req.acc) + NUM_W'(1);
            default: o_res = i_req.acc;
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/decimal_integer_line_parser_unit.sv */
// top level of the decimal line parser: sequencer, state and output register
//
// Usage:
//   i_char takes one received ASCII byte per transaction. Digits are pushed
//   onto a digit stack (dropped when full), backspace pops one digit, a minus
//   sign marks the number negative while no digit is held, other bytes are
//   ignored. CR or LF ends the line and produces one transaction on o_num
//   carrying the value modulo 2^32, negated if marked negative.
//   Throughput: a non-terminator byte leaves i_char.ready high. A
//   terminator walks the stored digits through the shared multiply-add
//   unit one per cycle, then the sign step loads the result into the
//   output register; i_char.ready is low from the accepted terminator
//   until that load.
//   The result waits in an output register; i_char keeps accepting while
//   o_num is stalled, but a following terminator holds in its sign step
//   until the pending result has been taken.
//   Reset (synchronous, active low) empties the stack, clears the sign and
//   drops any pending result.
`default_nettype none

module decimal_integer_line_parser_unit import dilp_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    dilp_char_if.sink    i_char,
    dilp_num_if.source   o_num
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt,   n_cnt;
    logic               r_neg,   n_neg;
    logic               r_out_vld, n_out_vld;
    logic               r_rd_vld,  n_rd_vld;
    logic [CNT_W-1:0]   r_idx,   n_idx;
    logic [NUM_W-1:0]   r_acc,   n_acc;
    logic [NUM_W-1:0]   r_num,   n_num;

    logic               in_fire;
    logic               is_term, is_bs, is_minus, is_digit;
    logic [CHAR_W-1:0]  ch;
    t_stk_wr            stk_wr;
    t_stk_rd            stk_rd;
    logic [DIGIT_W-1:0] rd_data;
    t_alu_req           alu_req;
    logic [NUM_W-1:0]   alu_res;

    // digit stack and shared arithmetic unit
    dilp_stack u_stack (
        .i_clk     (i_clk),
        .i_wr      (stk_wr),
        .i_rd      (stk_rd),
        .o_rd_data (rd_data)
    );

    dilp_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    // handshake and character decode
    assign i_char.ready       = (r_state == ST_IDLE);
    assign in_fire            = i_char.valid && i_char.ready;
    assign ch                 = i_char.char_code;
    assign is_term            = (ch == CH_CR) || (ch == CH_LF);
    assign is_bs              = (ch == CH_BS);
    assign is_minus           = (ch == CH_MINUS);
    assign is_digit           = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign o_num.valid        = r_out_vld;
    assign o_num.number_value = $signed(r_num);

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_neg     = r_neg;
        n_out_vld = r_out_vld;
        n_rd_vld  = r_rd_vld;
        n_idx     = r_idx;
        n_acc     = r_acc;
        n_num     = r_num;
        stk_wr    = '{en: 1'b0, addr: r_cnt[IDX_W-1:0], data: DIGIT_W'(ch - CH_ZERO)};
        stk_rd    = '{en: 1'b0, addr: r_idx[IDX_W-1:0]};
        alu_req   = '{op: ALU_MAC, acc: r_acc, digit: rd_data};

        // result taken by the receiver
        if (o_num.valid && o_num.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (is_term) begin
                        n_state  = ST_ACC;
                        n_idx    = '0;
                        n_rd_vld = 1'b0;
                        n_acc    = '0;
                    end else if (is_bs && (r_cnt != '0)) begin
                        n_cnt = CNT_W'(r_cnt - 1'b1);
                    end else if (is_minus && (r_cnt == '0)) begin
                        n_neg = 1'b1;
                    end else if (is_digit && (r_cnt < CNT_W'(STACK_DEPTH))) begin
                        stk_wr.en = 1'b1;
                        n_cnt     = CNT_W'(r_cnt + 1'b1);
                    end
                end
            end
            ST_ACC: begin
                // fold in the digit read last cycle
                if (r_rd_vld) begin
                    n_acc = alu_res;
                end
                if (r_idx != r_cnt) begin
                    stk_rd.en = 1'b1;
                    n_idx     = CNT_W'(r_idx + 1'b1);
                    n_rd_vld  = 1'b1;
                end else begin
                    n_rd_vld = 1'b0;
                    n_state  = ST_SIGN;
                end
            end
            ST_SIGN: begin
                alu_req.op = ALU_NEG;
                if (!r_out_vld || o_num.ready) begin
                    n_num     = r_neg ? alu_res : r_acc;
                    n_out_vld = 1'b1;
                    n_cnt     = '0;
                    n_neg     = 1'b0;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_neg     <= 1'b0;
            r_out_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_neg     <= n_neg;
            r_out_vld <= n_out_vld;
            r_rd_vld  <= n_rd_vld;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_acc <= n_acc;
        r_num <= n_num;
    end

    // digit count never exceeds the stack depth
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(STACK_DEPTH))
        else $error("digit count beyond stack depth");

    // a terminator always starts the digit walk
    a_term_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && is_term) |=> (r_state == ST_ACC))
        else $error("terminator did not start digit walk");

    // the walk index stays within the held digits
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACC) |-> (r_idx <= r_cnt))
        else $error("walk index beyond digit count");

    // a result only appears after the sign step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == ST_SIGN))
        else $error("result without sign step");

endmodule

`default_nettype wire

/* test/testbench.sv */
// self-checking testbench of the decimal integer line parser unit
`timescale 1ns / 1ps

module testbench;
    import dilp_pkg::*;

    localparam int CLK_HALF_NS  = 4;
    localparam int RESET_CYCLES = 9;
    localparam int TAIL_CYCLES  = 40;

    logic i_clk;
    logic i_rst_n;

    dilp_char_if u_char_if ();
    dilp_num_if  u_num_if ();

    decimal_integer_line_parser_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (u_char_if.sink),
        .o_num   (u_num_if.source)
    );

    // predicted line state
    logic [DIGIT_W-1:0] line_digits [STACK_DEPTH];
    logic [CNT_W-1:0]   line_count;
    logic               line_negative;

    logic signed [NUM_W-1:0] expected_numbers [$];
    int error_count;
    int sent_chars;

    // sender burst and receiver stall control
    bit tx_gaps_on;
    bit rx_stalls_on;
    int tx_burst_left;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF_NS) i_clk = ~i_clk;
    end

    // hard limit on run time
    initial begin
        #5ms;
        $display("decimal_integer_line_parser_unit test failed");
        $finish;
    end

    // update the predicted line state with one character; returns 1 on a line end
    function automatic bit parse_char(input logic [CHAR_W-1:0] c,
                                      output logic signed [NUM_W-1:0] number);
        logic [NUM_W-1:0] acc;
        acc = '0;
        number = '0;
        if (c == CH_CR || c == CH_LF) begin
            for (int k = 0; k < STACK_DEPTH; k++) begin
                if (k < line_count) acc = acc * 32'd10 + NUM_W'(line_digits[k]);
            end
            if (line_negative) acc = '0 - acc;
            number = acc;
            line_count = '0;
            line_negative = 1'b0;
            return 1'b1;
        end
        if (c == CH_BS && line_count != 0) begin
            line_count = line_count - 1'b1;
        end else if (c == CH_MINUS && line_count == 0) begin
            line_negative = 1'b1;
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            if (line_count < STACK_DEPTH) begin
                line_digits[line_count] = DIGIT_W'(c - CH_ZERO);
                line_count = line_count + 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // predict on each accepted character, check each accepted number
    always @(posedge i_clk) begin
        logic signed [NUM_W-1:0] number;
        logic signed [NUM_W-1:0] want;
        if (i_rst_n) begin
            if (u_char_if.valid && u_char_if.ready) begin
                if (parse_char(u_char_if.char_code, number)) expected_numbers.push_back(number);
            end
            if (u_num_if.valid && u_num_if.ready) begin
                if (expected_numbers.size() == 0) begin
                    $error("number_value: no result expected, actual %0d",
                           u_num_if.number_value);
                    error_count++;
                end else begin
                    want = expected_numbers.pop_front();
                    if (u_num_if.number_value !== want) begin
                        $error("number_value mismatch: expected %0d actual %0d",
                               want, u_num_if.number_value);
                        error_count++;
                    end
                end
            end
        end
    end

    // receiver: always ready, or alternating runs of ready and stall when stalls are on
    initial begin
        int run;
        bit level;
        u_num_if.ready = 1'b0;
        run = 0;
        level = 1'b1;
        forever begin
            @(negedge i_clk);
            if (!rx_stalls_on) begin
                u_num_if.ready <= 1'b1;
            end else begin
                if (run == 0) begin
                    level = ~level;
                    run = level ? $urandom_range(1, 12) : $urandom_range(1, 20);
                end
                run--;
                u_num_if.ready <= level;
            end
        end
    end

    // send one character, with a random gap at the start of each burst when gaps are on
    task automatic send_char(input logic [CHAR_W-1:0] c);
        int gap;
        gap = 0;
        if (tx_gaps_on) begin
            if (tx_burst_left == 0) begin
                gap = $urandom_range(1, 8);
                tx_burst_left = $urandom_range(1, 12);
            end
            tx_burst_left--;
        end
        repeat (gap) begin
            @(negedge i_clk);
            u_char_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        u_char_if.valid     <= 1'b1;
        u_char_if.char_code <= c;
        do @(posedge i_clk); while (!u_char_if.ready);
        sent_chars++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    // hold the sender idle until every predicted number has come out
    task automatic wait_drained();
        @(negedge i_clk);
        u_char_if.valid <= 1'b0;
        while (expected_numbers.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_terminator();
        send_char(($urandom_range(0, 1) == 0) ? CH_CR : CH_LF);
    endtask

    // empty lines, plain and with repeated minus
    task automatic test_empty_lines();
        send_char(CH_LF);
        send_char(CH_MINUS);
        send_char(CH_MINUS);
        send_char(CH_CR);
    endtask

    // backspace, minus rules and ignored bytes inside one line
    task automatic test_edit_keys();
        send_char(CH_BS);
        send_text("0");
        send_char(CH_BS);
        send_char(CH_MINUS);
        send_char(8'h00);
        send_text("3");
        send_char(CH_MINUS);
        send_char(8'hFF);
        send_text("9");
        send_char(CH_BS);
        send_text("8");
        send_char(CH_LF);
    endtask

    // full stack with a dropped extra digit, value wraps
    task automatic test_full_stack();
        send_text("123456789098765");
        send_text("4");
        send_char(CH_CR);
    endtask

    // one random line: mostly well formed, some noise and broken lines
    task automatic send_random_line();
        int kind;
        int len;
        int pick;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            len = $urandom_range(1, 6);
            repeat (len) send_char(CHAR_W'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 2) == 0) send_char(CH_MINUS);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 18) : $urandom_range(0, 10);
            repeat (len) begin
                pick = $urandom_range(0, 19);
                if (pick == 0) send_char(CH_BS);
                else if (pick == 1) send_char(CHAR_W'($urandom_range(0, 255)));
                else if (pick == 2) send_char(CH_MINUS);
                send_char(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
            end
        end
        send_terminator();
    endtask

    task automatic test_random_lines(input int n_chars);
        int stop_at;
        stop_at = sent_chars + n_chars;
        while (sent_chars < stop_at) send_random_line();
    endtask

    // sender waits for every pending number after the first of each three lines
    task automatic test_drain_pause();
        repeat (3) begin
            send_random_line();
            wait_drained();
            send_random_line();
            send_random_line();
        end
    endtask

    initial begin
        error_count = 0;
        sent_chars = 0;
        tx_gaps_on = 1'b0;
        rx_stalls_on = 1'b0;
        tx_burst_left = 0;
        line_count = '0;
        line_negative = 1'b0;
        for (int k = 0; k < STACK_DEPTH; k++) line_digits[k] = '0;
        u_char_if.valid = 1'b0;
        u_char_if.char_code = '0;
        i_rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part with both sides idling
        tx_gaps_on = 1'b1;
        rx_stalls_on = 1'b1;
        test_empty_lines();
        test_edit_keys();
        test_full_stack();

        // random part through several idling mixes
        test_random_lines(300);
        tx_gaps_on = 1'b0;
        rx_stalls_on = 1'b0;
        test_random_lines(200);
        rx_stalls_on = 1'b1;
        test_random_lines(150);
        tx_gaps_on = 1'b1;
        rx_stalls_on = 1'b0;
        test_random_lines(150);
        rx_stalls_on = 1'b1;
        test_drain_pause();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("decimal_integer_line_parser_unit test passed");
        end else begin
            $display("decimal_integer_line_parser_unit test failed");
        end
        $finish;
    end

endmodule
